@@ hw/rtl/deq_pkg.sv @@
// Shared constants, codes and ring-index helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = 32;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_TRAVERSE   = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // (idx + off) mod DEPTH, with idx < DEPTH and off <= DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(idx) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
    endfunction

endpackage

@@ hw/rtl/deq_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module deq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH_P = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/double_ended_queue_core.sv @@
// Double-ended queue core: ring-buffer deque of signed 32-bit words in one RAM.
//
// Each input transfer carries one operation (push back, push front, pop back,
// pop front, traverse) and a value. Pushes and pops each give one status
// transfer with last set; a push onto a full queue is refused with status
// full, a pop from an empty queue reports empty. A traverse of N stored
// words gives N transfers, front to back, each with its word, and last set
// on the final one; on an empty queue it gives a single empty transfer.
// Unused opcodes are taken and dropped without a result. Rate: a push or
// pop is accepted every cycle while the output keeps up. In a traverse the
// accepting cycle issues the first RAM read, then one word per cycle leaves
// the single RAM read port while the output keeps up, and input is held off
// until the last word has been handed to the output. The store needs no
// clearing pass after reset: only words that were pushed are ever read back.
module double_ended_queue_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [deq_pkg::WORD_W-1:0]  word,
    output logic                               last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TRAV = 1'b1;

    localparam int IDX_W = deq_pkg::IDX_W;
    localparam int CNT_W = deq_pkg::CNT_W;
    localparam int WORD_W = deq_pkg::WORD_W;

    // queue state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             state_reg, state_next;

    // traverse sequencing: reads issued, next read address, word waiting in RAM
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              last_reg, last_next;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic out_free;
    logic in_fire;
    logic full;
    logic empty;
    logic take;
    logic issue_trav;
    logic issue_start;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(deq_pkg::DEPTH));
    assign empty    = (count_reg == '0);

    // traverse: hand the RAM word to the output, and refill the read slot
    assign take        = (state_reg == S_TRAV) && pend_reg && out_free;
    assign issue_trav  = (state_reg == S_TRAV) && (rd_cnt_reg != count_reg)
                         && (!pend_reg || take);
    assign issue_start = in_fire && (opcode == deq_pkg::OP_TRAVERSE) && !empty;

    // Writes come only from pushes taken in idle, reads only from traverse,
    // and a traverse is never accepted in the same cycle as a push, so a read
    // never meets a write to the same entry in the same cycle.
    assign ram_re    = issue_start || issue_trav;
    assign ram_raddr = issue_start ? front_reg : rd_addr_reg;
    assign ram_we    = in_fire && !full
                       && ((opcode == deq_pkg::OP_PUSH_BACK)
                           || (opcode == deq_pkg::OP_PUSH_FRONT));
    assign ram_waddr = (opcode == deq_pkg::OP_PUSH_FRONT)
                       ? deq_pkg::ring_dec(front_reg)
                       : deq_pkg::ring_add(front_reg, count_reg);

    deq_ram #(
        .DATA_W (WORD_W),
        .DEPTH_P(deq_pkg::DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        word_next      = word_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // default single status result
                    status_next = deq_pkg::STAT_OK;
                    word_next   = '0;
                    last_next   = 1'b1;
                    unique case (opcode)
                        deq_pkg::OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_PUSH_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                front_next = deq_pkg::ring_dec(front_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_POP_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = deq_pkg::ring_inc(front_reg);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_TRAVERSE:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // first read goes out this cycle
                                state_next     = S_TRAV;
                                rd_cnt_next    = CNT_W'(1);
                                rd_addr_next   = deq_pkg::ring_inc(front_reg);
                                pend_next      = 1'b1;
                                pend_last_next = (count_reg == CNT_W'(1));
                            end
                        end
                        default:
                        begin
                            // unused opcode: dropped, no result
                        end
                    endcase
                end
            end
            S_TRAV:
            begin
                if (take)
                begin
                    out_valid_next = 1'b1;
                    status_next    = deq_pkg::STAT_OK;
                    word_next      = ram_rdata;
                    last_next      = pend_last_reg;
                    pend_next      = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (issue_trav)
                begin
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                    rd_addr_next   = deq_pkg::ring_inc(rd_addr_reg);
                    pend_next      = 1'b1;
                    pend_last_next = ((rd_cnt_reg + CNT_W'(1)) == count_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        status_reg  <= status_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign word      = word_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // fill level never passes the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(deq_pkg::DEPTH))
        else $error("entry count above depth");

    // a word waiting in the RAM belongs to a traverse in progress
    a_pend_in_trav: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_TRAV) && (rd_cnt_reg != '0))
        else $error("pending read outside traverse");

    // never read more words than are stored
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRAV) |-> (rd_cnt_reg <= count_reg))
        else $error("traverse read past the back");

    // a successful push grows the queue by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ram_we) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not update count");
`endif

endmodule

@@ sim/deq_checker.sv @@
// Deque checker: mirrors the queue contents and compares every result transfer.
`timescale 1ns / 1ps

module deq_checker
    import deq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic signed [WORD_W-1:0]  value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [1:0]                status,
    input  logic signed [WORD_W-1:0]  word,
    input  logic                      last,
    output int                        errors,
    output int                        pending
);

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } result_t;

    // mirror of the ring store, front position and fill level
    logic signed [WORD_W-1:0] ring [DEPTH];
    int                       head;
    int                       fill;
    result_t                  due_results [$];
    int                       err_count = 0;

    function automatic result_t make_result(input logic [1:0] s,
                                            input logic signed [WORD_W-1:0] w,
                                            input logic l);
        result_t r;
        r.status = s;
        r.word   = w;
        r.last   = l;
        return r;
    endfunction

    function automatic void apply_deque_op(input logic [2:0] op,
                                           input logic signed [WORD_W-1:0] v);
        int i;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (fill >= DEPTH)
                begin
                    due_results.push_back(make_result(STAT_FULL, '0, 1'b1));
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = v;
                    end
                    else
                    begin
                        ring[(head + fill) % DEPTH] = v;
                    end
                    fill++;
                    due_results.push_back(make_result(STAT_OK, '0, 1'b1));
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (fill == 0)
                begin
                    due_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        head = (head + 1) % DEPTH;
                    end
                    fill--;
                    due_results.push_back(make_result(STAT_OK, '0, 1'b1));
                end
            end
            OP_TRAVERSE:
            begin
                if (fill == 0)
                begin
                    due_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
                end
                else
                begin
                    for (i = 0; i < fill; i++)
                    begin
                        due_results.push_back(make_result(STAT_OK,
                                                          ring[(head + i) % DEPTH],
                                                          i == fill - 1));
                    end
                end
            end
            default:
            begin
                // unused opcodes are dropped silently
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            head = 0;
            fill = 0;
            due_results.delete();
        end
        else
        begin
            // input first: covers a result that leaves in the same cycle
            if (in_valid && in_ready)
            begin
                apply_deque_op(opcode, value);
            end
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t unexpected result: status %0d word %0d last %0d",
                             $time, status, word, last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status || word !== want.word ||
                        last !== want.last)
                    begin
                        err_count++;
                        $display("%0t mismatch: expected status %0d word %0d last %0d,",
                                 $time, want.status, want.word, want.last,
                                 " got status %0d word %0d last %0d",
                                 status, word, last);
                    end
                end
            end
        end
        errors  <= err_count;
        pending <= due_results.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the deque core: stimulus, handshake idling and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import deq_pkg::*;

    // opcodes with no meaning; the core takes them and gives nothing back
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 2000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [2:0]               opcode    = OP_PUSH_BACK;
    logic signed [WORD_W-1:0] value     = '0;
    logic                     out_ready = 1'b0;

    logic                     in_ready;
    logic                     out_valid;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] word;
    logic                     last;

    int errors;
    int pending;

    // rough fill level, only used to steer the stimulus toward full and empty
    int level = 0;
    // set for the no-idle stretch: both sides run flat out
    bit calm  = 1'b0;
    int quiet = 0;

    double_ended_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .word      (word),
        .last      (last)
    );

    deq_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .word      (word),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side backpressure: drop ready on roughly 37% of cycles, except
    // during the calm stretch.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 37);
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet <= 0;
            end
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("double_ended_queue_core verification failed");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    // Mostly random words, with the sign and all-ones/all-zeros corners mixed in.
    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(11))
            0:       return {1'b0, {(WORD_W-1){1'b1}}};
            1:       return {1'b1, {(WORD_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Weighted operation pick. What is left after pushes and pops goes about
    // two thirds to traverse and one third to unused opcodes.
    function automatic logic [2:0] pick_op(input int push_pct, input int pop_pct);
        int r;
        int rest;
        r    = $urandom_range(99);
        rest = 100 - push_pct - pop_pct;
        if (r < push_pct)
        begin
            return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        if (r < push_pct + pop_pct)
        begin
            return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        end
        if (r < push_pct + pop_pct + rest * 2 / 3)
        begin
            return OP_TRAVERSE;
        end
        return 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    endfunction

    // One input transfer. Valid is only dropped inside an idle gap, so back to
    // back transfers never lower and raise it in the same step.
    task automatic send_op(input logic [2:0] op, input logic signed [WORD_W-1:0] v);
        if (!calm)
        begin
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: if (level < DEPTH) level++;
            OP_POP_BACK, OP_POP_FRONT:   if (level > 0) level--;
            default:                     ;
        endcase
    endtask

    initial
    begin : stimulus
        int k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue cases, extreme words, head wrap on the first
        // push at the front, unused opcodes, a drain back to empty, then two pushes.
        send_op(OP_TRAVERSE,   '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_POP_FRONT,  '1);
        send_op(OP_PUSH_BACK,  32'sh7fff_ffff);
        send_op(OP_PUSH_FRONT, 32'sh8000_0000);
        send_op(OP_PUSH_BACK,  '0);
        send_op(OP_PUSH_FRONT, '1);
        send_op(OP_TRAVERSE,   '0);
        send_op(OP_UNUSED_FIRST, 32'sh1234_5678);
        send_op(3'(OP_UNUSED_FIRST + 3'd1), '1);
        send_op(OP_UNUSED_LAST, '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_TRAVERSE,   '0);
        send_op(OP_POP_FRONT,  '0);
        send_op(OP_TRAVERSE,   '0);
        send_op(OP_POP_FRONT,  '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_TRAVERSE,   '0);
        send_op(OP_PUSH_FRONT, 32'sh5555_5555);
        send_op(OP_PUSH_BACK,  32'shaaaa_aaaa);
        send_op(OP_TRAVERSE,   '0);

        // Random mix around a shallow fill level.
        for (k = 0; k < 10; k++)
        begin
            send_op(pick_op(40, 35), rand_word());
        end

        // Fill to the brim, knock on the full queue, then walk all of it.
        while (level < DEPTH)
        begin
            send_op(pick_op(92, 4), rand_word());
        end
        repeat (3) send_op(pick_op(100, 0), rand_word());
        send_op(OP_TRAVERSE, rand_word());

        // No idling on either side for the last stretch, leaning on pops.
        calm = 1'b1;
        for (k = 0; k < 25; k++)
        begin
            send_op(pick_op(25, 55), rand_word());
        end
        in_valid <= 1'b0;

        // wait so the checker has counted the last transfer
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("double_ended_queue_core verification clean");
        end
        else
        begin
            $display("double_ended_queue_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue_core.sv
sim/deq_checker.sv
sim/tb_top.sv
